/* rtl/jbt_pkg.sv */
// Package for the JSON byte tokenizer: token kinds, byte codes, the token
// record and the position cap. No dependencies.
`default_nettype none

package jbt_pkg;

  localparam longint unsigned MaxTextBytes = 64'd65536;
  localparam logic [15:0] POS_CAP =
    16'((MaxTextBytes - 64'd1 > 64'd65535) ? 64'd65535 : MaxTextBytes - 64'd1);
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW = 2;

  typedef enum logic [3:0] {
    KIND_INT    = 4'd0,
    KIND_DOUBLE = 4'd1,
    KIND_STRING = 4'd2,
    KIND_TRUE   = 4'd3,
    KIND_FALSE  = 4'd4,
    KIND_NULL   = 4'd5,
    KIND_AOPEN  = 4'd6,
    KIND_ACLOSE = 4'd7,
    KIND_OOPEN  = 4'd8,
    KIND_OCLOSE = 4'd9,
    KIND_COMMA  = 4'd10,
    KIND_COLON  = 4'd11,
    KIND_ERROR  = 4'd12
  } kind_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic push0;
    logic push1;
    tok_t tok0;
    tok_t tok1;
  } push_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v >= POS_CAP) ? POS_CAP : v + 16'd1;
  endfunction

  function automatic logic [15:0] span(input logic [15:0] from, input logic [15:0] to);
    span = (to >= from) ? to - from : 16'd0;
  endfunction

endpackage

`default_nettype wire

/* rtl/jbt_if.sv */
// Channel interfaces for the JSON byte tokenizer: text bytes in, tokens out.
// No dependencies.
`default_nettype none

interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface jbt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;
  modport source (output valid, token_kind, token_start, token_length, last_of_run,
                  input ready);
  modport sink (input valid, token_kind, token_start, token_length, last_of_run,
                output ready);
endinterface

`default_nettype wire

/* rtl/jbt_lexer.sv */
// Byte register and lexer state machine; produces up to two tokens per byte.
// Depends on jbt_pkg and jbt_in_if.
`default_nettype none

module jbt_lexer
  import jbt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  jbt_in_if.sink    in_ch,
  input  wire logic space_ok,
  output push_t     push
);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_STRING = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_SKIP   = 3'd3,
    MODE_ERROR  = 3'd4
  } mode_t;

  logic        in_v_r;
  logic [7:0]  byte_r;
  logic        last_r;
  mode_t       mode_r, mode_nxt;
  logic        esc_r, esc_nxt;
  logic        dot_r, dot_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] ls_r, ls_nxt;
  logic [2:0]  skip_r, skip_nxt;

  logic  go;
  logic  idle_run, is_digit;
  logic  a_v, b_v, c_v;
  tok_t  tok_a, tok_b, tok_c;
  logic [15:0] num_len;

  assign go = in_v_r && space_ok;
  assign in_ch.ready = !in_v_r || space_ok;
  assign is_digit = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);

  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    dot_nxt  = dot_r;
    ls_nxt   = ls_r;
    skip_nxt = skip_r;
    pos_nxt  = pos_r;
    idle_run = 1'b0;
    a_v = 1'b0;
    b_v = 1'b0;
    c_v = 1'b0;
    tok_a = '0;
    tok_b = '0;
    tok_c = '0;
    num_len = 16'd0;

    unique case (mode_r)
      MODE_STRING: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (byte_r == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (byte_r == CH_QUOTE) begin
          a_v = 1'b1;
          tok_a.kind = KIND_STRING;
          tok_a.start = ls_r;
          tok_a.length = span(ls_r, pos_r);
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit || byte_r == CH_DOT) begin
          if (byte_r == CH_DOT) begin
            dot_nxt = 1'b1;
          end
        end else begin
          a_v = 1'b1;
          tok_a.kind = dot_r ? KIND_DOUBLE : KIND_INT;
          tok_a.start = ls_r;
          tok_a.length = span(ls_r, pos_r);
          mode_nxt = MODE_IDLE;
          idle_run = 1'b1;
        end
      end
      MODE_SKIP: begin
        if (skip_r != 3'd0) begin
          skip_nxt = skip_r - 3'd1;
        end
        if (skip_nxt == 3'd0) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_ERROR: begin
      end
      default: begin
        mode_nxt = MODE_IDLE;
        idle_run = 1'b1;
      end
    endcase

    if (idle_run) begin
      tok_b.start = pos_r;
      tok_b.length = 16'd1;
      if (byte_r == CH_SPACE || (byte_r >= CH_TAB && byte_r <= CH_CR)) begin
      end else if (byte_r == CH_QUOTE) begin
        mode_nxt = MODE_STRING;
        esc_nxt = 1'b0;
        ls_nxt = sat_inc(pos_r);
      end else if (is_digit || byte_r == CH_MINUS) begin
        mode_nxt = MODE_NUMBER;
        dot_nxt = 1'b0;
        ls_nxt = pos_r;
      end else begin
        b_v = 1'b1;
        unique case (byte_r)
          CH_LC_T: begin
            tok_b.kind = KIND_TRUE;
            tok_b.length = 16'd4;
            skip_nxt = 3'd3;
            mode_nxt = MODE_SKIP;
          end
          CH_LC_F: begin
            tok_b.kind = KIND_FALSE;
            tok_b.length = 16'd5;
            skip_nxt = 3'd4;
            mode_nxt = MODE_SKIP;
          end
          CH_LC_N: begin
            tok_b.kind = KIND_NULL;
            tok_b.length = 16'd4;
            skip_nxt = 3'd3;
            mode_nxt = MODE_SKIP;
          end
          CH_LBRACK: tok_b.kind = KIND_AOPEN;
          CH_RBRACK: tok_b.kind = KIND_ACLOSE;
          CH_LBRACE: tok_b.kind = KIND_OOPEN;
          CH_RBRACE: tok_b.kind = KIND_OCLOSE;
          CH_COMMA:  tok_b.kind = KIND_COMMA;
          CH_COLON:  tok_b.kind = KIND_COLON;
          default: begin
            tok_b.kind = KIND_ERROR;
            mode_nxt = MODE_ERROR;
          end
        endcase
      end
    end

    if (last_r) begin
      num_len = span(ls_nxt, pos_r);
      if (mode_nxt == MODE_NUMBER) begin
        c_v = 1'b1;
        tok_c.kind = dot_nxt ? KIND_DOUBLE : KIND_INT;
        tok_c.start = ls_nxt;
        tok_c.length = (num_len == LEN_MAX) ? LEN_MAX : num_len + 16'd1;
      end else if (mode_nxt == MODE_STRING) begin
        c_v = 1'b1;
        tok_c.kind = KIND_ERROR;
        tok_c.start = pos_r;
        tok_c.length = 16'd1;
      end
      mode_nxt = MODE_IDLE;
      esc_nxt  = 1'b0;
      dot_nxt  = 1'b0;
      ls_nxt   = 16'd0;
      skip_nxt = 3'd0;
      pos_nxt  = 16'd0;
    end else begin
      pos_nxt = sat_inc(pos_r);
    end
  end

  always_comb begin
    push.push0 = go && (a_v || b_v || c_v);
    push.push1 = go && ((a_v && (b_v || c_v)) || (b_v && c_v));
    push.tok0 = a_v ? tok_a : (b_v ? tok_b : tok_c);
    push.tok1 = a_v ? (b_v ? tok_b : tok_c) : tok_c;
    push.tok0.last = !push.push1;
    push.tok1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      mode_r <= MODE_IDLE;
      esc_r  <= 1'b0;
      dot_r  <= 1'b0;
      pos_r  <= 16'd0;
      ls_r   <= 16'd0;
      skip_r <= 3'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_v_r <= 1'b1;
        byte_r <= in_ch.text_byte;
        last_r <= in_ch.end_of_text;
      end else if (go) begin
        in_v_r <= 1'b0;
      end
      if (go) begin
        mode_r <= mode_nxt;
        esc_r  <= esc_nxt;
        dot_r  <= dot_nxt;
        pos_r  <= pos_nxt;
        ls_r   <= ls_nxt;
        skip_r <= skip_nxt;
      end
    end
  end

  a_err_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (go && mode_r == MODE_ERROR && !last_r) |=> (mode_r == MODE_ERROR))
    else $error("error mode left before end of text");

  a_pos_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (go && last_r) |=> (pos_r == 16'd0 && mode_r == MODE_IDLE))
    else $error("state not cleared after last byte");

  a_no_third: assert property (@(posedge clk) disable iff (!rst_n)
    !(a_v && b_v && c_v))
    else $error("three tokens from one byte");

endmodule

`default_nettype wire

/* rtl/jbt_tok_fifo.sv */
// Four-entry token queue: takes up to two tokens a cycle, hands out one.
// Depends on jbt_pkg and jbt_out_if.
`default_nettype none

module jbt_tok_fifo
  import jbt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       space_ok,
  jbt_out_if.source  out_ch
);

  tok_t                mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_r, rd_r;
  logic [FIFO_AW:0]    cnt_r, cnt_nxt;
  logic                pop;
  logic [1:0]          n_push;
  tok_t                head;

  assign pop      = out_ch.valid && out_ch.ready;
  assign space_ok = cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
  assign n_push   = {1'b0, push.push0} + {1'b0, push.push1};
  assign cnt_nxt  = cnt_r + (FIFO_AW + 1)'(n_push) - (FIFO_AW + 1)'(pop);
  assign head     = mem[rd_r];

  assign out_ch.valid        = cnt_r != '0;
  assign out_ch.token_kind   = head.kind;
  assign out_ch.token_start  = head.start;
  assign out_ch.token_length = head.length;
  assign out_ch.last_of_run  = head.last;

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_r] <= push.tok0;
    end
    if (push.push1) begin
      mem[wr_r + FIFO_AW'(1)] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + FIFO_AW'(n_push);
      rd_r  <= rd_r + FIFO_AW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("token queue overflow");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0)
    else $error("second token without first");

  a_space_push: assert property (@(posedge clk) disable iff (!rst_n)
    push.push0 |-> space_ok)
    else $error("push without room");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.push0) |=> (cnt_r == $past(cnt_r) - (FIFO_AW + 1)'(1)))
    else $error("count not reduced on transfer");

endmodule

`default_nettype wire

/* rtl/json_byte_tokenizer_core.sv */
// Top level of the JSON byte tokenizer: lexer plus token queue.
// Depends on jbt_pkg, jbt_if, jbt_lexer and jbt_tok_fifo.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          text_byte[7:0], end_of_text
//   out_ch   out  valid/ready          token_kind[3:0], token_start[15:0],
//                                      token_length[15:0], last_of_run
//
// One byte per cycle is taken unless the lexer waits for queue room; a byte is
// held in byte_r after its transfer and lexed from there. Its tokens (zero to
// two) go into the queue and leave on out_ch one per cycle while it is ready;
// the four-entry queue sets how far the input runs ahead of a stalled output.
// Reset is synchronous, active low, and clears all lexer state and the queue.
`default_nettype none

module json_byte_tokenizer_core
  import jbt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  jbt_in_if.sink    in_ch,
  jbt_out_if.source out_ch
);

  push_t push;
  logic  space_ok;

  jbt_lexer u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .space_ok (space_ok),
    .push     (push)
  );

  jbt_tok_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// Testbench for json_byte_tokenizer_core: feeds JSON text bytewise, checks each
// token to a local lexer model or a typed row. Needs jbt_pkg, jbt_if, core RTL.
module tb;
  import jbt_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 560;
  localparam logic [47:0] WS_SET =
    {CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
  localparam logic [47:0] PUNCT_SET =
    {CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_COLON};

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_STRING, SCAN_NUMBER, SCAN_SKIP, SCAN_ERROR
  } scan_t;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    tok_t       tok;
  } row_t;

  logic clk;
  logic rst_n;

  jbt_in_if  in_if ();
  jbt_out_if out_if ();

  json_byte_tokenizer_core DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  scan_t       scan;
  logic        in_escape;
  logic        seen_dot;
  logic [15:0] cur_pos;
  logic [15:0] tok_begin;
  logic [2:0]  skip_left;

  tok_t       fresh[$];
  tok_t       expected_toks[$];
  tok_t       head_tok;
  logic [7:0] text_q[$];

  int unsigned src_idle;
  int unsigned snk_idle;
  int          hold_req;
  int          hold_done;
  int          hold_left;
  int          idle_cycles;
  int          errors;
  int          bytes_sent;
  int          tokens_seen;
  int          streams_sent;

  row_t dir_rows [26] = '{
    '{CH_LBRACK, 1'b0, 1'b1, '{KIND_AOPEN, 16'd0, 16'd1, 1'b1}},
    '{CH_TAB, 1'b0, 1'b0, '0},
    '{CH_QUOTE, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_QUOTE, 1'b0, 1'b0, '0},
    '{CH_QUOTE, 1'b0, 1'b0, '0},
    '{CH_COLON, 1'b0, 1'b1, '{KIND_COLON, 16'd6, 16'd1, 1'b1}},
    '{CH_MINUS, 1'b0, 1'b0, '0},
    '{CH_DOT, 1'b0, 1'b0, '0},
    '{8'h39, 1'b0, 1'b0, '0},
    '{CH_RBRACK, 1'b0, 1'b0, '0},
    '{CH_LC_N, 1'b0, 1'b1, '{KIND_NULL, 16'd11, 16'd4, 1'b1}},
    '{8'h75, 1'b1, 1'b0, '0},
    '{CH_LBRACE, 1'b0, 1'b1, '{KIND_OOPEN, 16'd0, 16'd1, 1'b1}},
    '{CH_ZERO, 1'b0, 1'b0, '0},
    '{CH_LC_T, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h0C, 1'b0, 1'b0, '0},
    '{CH_RBRACE, 1'b0, 1'b1, '{KIND_OCLOSE, 16'd6, 16'd1, 1'b1}},
    '{CH_COMMA, 1'b0, 1'b1, '{KIND_COMMA, 16'd7, 16'd1, 1'b1}},
    '{8'h35, 1'b1, 1'b0, '0},
    '{8'h0B, 1'b0, 1'b0, '0},
    '{CH_QUOTE, 1'b1, 1'b1, '{KIND_ERROR, 16'd1, 16'd1, 1'b1}},
    '{8'h01, 1'b0, 1'b1, '{KIND_ERROR, 16'd0, 16'd1, 1'b1}},
    '{CH_LBRACK, 1'b1, 1'b0, '0}
  };

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v >= POS_CAP) ? POS_CAP : v + 16'd1;
  endfunction

  function automatic logic [15:0] distance(input logic [15:0] from, input logic [15:0] to);
    return (to >= from) ? to - from : 16'd0;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void restart_stream();
    scan = SCAN_IDLE;
    in_escape = 1'b0;
    seen_dot = 1'b0;
    cur_pos = '0;
    tok_begin = '0;
    skip_left = '0;
  endfunction

  function automatic void add_tok(input kind_t k, input logic [15:0] s, input logic [15:0] l);
    tok_t t;
    if (fresh.size() < 2) begin
      t.kind = k;
      t.start = s;
      t.length = l;
      t.last = 1'b0;
      fresh.push_back(t);
    end
  endfunction

  function automatic void idle_byte(input logic [7:0] c, input logic [15:0] p);
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
    if (c == CH_QUOTE) begin
      scan = SCAN_STRING;
      in_escape = 1'b0;
      tok_begin = bump(p);
      return;
    end
    if (is_digit(c) || c == CH_MINUS) begin
      scan = SCAN_NUMBER;
      seen_dot = 1'b0;
      tok_begin = p;
      return;
    end
    case (c)
      CH_LC_T: begin
        add_tok(KIND_TRUE, p, 16'd4);
        skip_left = 3'd3;
        scan = SCAN_SKIP;
      end
      CH_LC_F: begin
        add_tok(KIND_FALSE, p, 16'd5);
        skip_left = 3'd4;
        scan = SCAN_SKIP;
      end
      CH_LC_N: begin
        add_tok(KIND_NULL, p, 16'd4);
        skip_left = 3'd3;
        scan = SCAN_SKIP;
      end
      CH_LBRACK: add_tok(KIND_AOPEN, p, 16'd1);
      CH_RBRACK: add_tok(KIND_ACLOSE, p, 16'd1);
      CH_LBRACE: add_tok(KIND_OOPEN, p, 16'd1);
      CH_RBRACE: add_tok(KIND_OCLOSE, p, 16'd1);
      CH_COMMA:  add_tok(KIND_COMMA, p, 16'd1);
      CH_COLON:  add_tok(KIND_COLON, p, 16'd1);
      default: begin
        add_tok(KIND_ERROR, p, 16'd1);
        scan = SCAN_ERROR;
      end
    endcase
  endfunction

  // Lex one byte; the tokens it causes land in fresh.
  function automatic void lex_byte(input logic [7:0] c, input logic eot);
    logic [15:0] p;
    logic [15:0] n;
    p = cur_pos;
    fresh.delete();
    case (scan)
      SCAN_STRING: begin
        if (in_escape) in_escape = 1'b0;
        else if (c == CH_BSLASH) in_escape = 1'b1;
        else if (c == CH_QUOTE) begin
          add_tok(KIND_STRING, tok_begin, distance(tok_begin, p));
          scan = SCAN_IDLE;
        end
      end
      SCAN_NUMBER: begin
        if (is_digit(c) || c == CH_DOT) begin
          if (c == CH_DOT) seen_dot = 1'b1;
        end else begin
          add_tok(seen_dot ? KIND_DOUBLE : KIND_INT, tok_begin, distance(tok_begin, p));
          scan = SCAN_IDLE;
          idle_byte(c, p);
        end
      end
      SCAN_SKIP: begin
        if (skip_left != 3'd0) skip_left = skip_left - 3'd1;
        if (skip_left == 3'd0) scan = SCAN_IDLE;
      end
      SCAN_ERROR: ;
      default: begin
        scan = SCAN_IDLE;
        idle_byte(c, p);
      end
    endcase
    if (eot) begin
      if (scan == SCAN_NUMBER) begin
        n = distance(tok_begin, p);
        n = (n == LEN_MAX) ? n : n + 16'd1;
        add_tok(seen_dot ? KIND_DOUBLE : KIND_INT, tok_begin, n);
      end else if (scan == SCAN_STRING) begin
        add_tok(KIND_ERROR, p, 16'd1);
      end
      restart_stream();
    end else begin
      cur_pos = bump(p);
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eot,
                           input logic typed = 1'b0, input tok_t typed_tok = '0);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.text_byte <= c;
    in_if.end_of_text <= eot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    lex_byte(c, eot);
    if (typed) expected_toks.push_back(typed_tok);
    else foreach (fresh[i]) expected_toks.push_back(fresh[i]);
    bytes_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_toks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void put_word(input string w);
    for (int i = 0; i < w.len(); i++) text_q.push_back(w[i]);
  endfunction

  function automatic void put_chars();
    int n;
    logic [7:0] b;
    n = $urandom_range(5);
    repeat (n) begin
      if ($urandom_range(6) == 0) begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(8'($urandom_range(255)));
      end else begin
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
        text_q.push_back(b);
      end
    end
  endfunction

  function automatic void put_number();
    int n;
    if ($urandom_range(1) == 1) text_q.push_back(CH_MINUS);
    n = $urandom_range(1, 5);
    repeat (n) begin
      if ($urandom_range(4) == 0) text_q.push_back(CH_DOT);
      else text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
  endfunction

  // Mostly well-formed token runs; a few raw bytes and unfinished endings.
  function automatic void compose_stream();
    int pieces;
    int pick;
    text_q.delete();
    pieces = $urandom_range(1, 24);
    repeat (pieces) begin
      pick = $urandom_range(99);
      if (pick < 15) text_q.push_back(WS_SET[8 * $urandom_range(5) +: 8]);
      else if (pick < 40) text_q.push_back(PUNCT_SET[8 * $urandom_range(5) +: 8]);
      else if (pick < 60) begin
        text_q.push_back(CH_QUOTE);
        put_chars();
        text_q.push_back(CH_QUOTE);
      end else if (pick < 80) put_number();
      else if (pick < 97) begin
        case ($urandom_range(2))
          0: put_word("true");
          1: put_word("false");
          default: put_word("null");
        endcase
      end else text_q.push_back(8'($urandom_range(255)));
    end
    case ($urandom_range(5))
      0: begin
        text_q.push_back(CH_QUOTE);
        put_chars();
      end
      1: put_number();
      2: text_q.push_back(CH_LC_F);
      default: ;
    endcase
  endfunction

  task automatic run_streams(input int target);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < target) begin
      compose_stream();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      streams_sent++;
    end
  endtask

  function automatic void match_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      tokens_seen++;
      if (expected_toks.size() == 0) begin
        errors++;
        $display("%0t: unexpected token, expected none, got kind %0d start %0d length %0d",
                 $time, out_if.token_kind, out_if.token_start, out_if.token_length);
      end else begin
        head_tok = expected_toks.pop_front();
        match_field("token_kind", head_tok.kind, out_if.token_kind);
        match_field("token_start", head_tok.start, out_if.token_start);
        match_field("token_length", head_tok.length, out_if.token_length);
        match_field("last_of_run", head_tok.last, out_if.last_of_run);
      end
    end
    if (hold_done != hold_req) begin
      hold_done = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.text_byte = '0;
    in_if.end_of_text = 1'b0;
    out_if.ready = 1'b0;
    src_idle = 0;
    snk_idle = 0;
    hold_req = 0;
    hold_done = 0;
    hold_left = 0;
    idle_cycles = 0;
    errors = 0;
    bytes_sent = 0;
    tokens_seen = 0;
    streams_sent = 0;
    restart_stream();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed,
                                    dir_rows[i].tok);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 20 : (ph == 1) ? 79 : 0;
      snk_idle = (ph == 0) ? 79 : (ph == 1) ? 20 : 0;
      if (ph == 2) hold_req++;
      run_streams(PHASE_BYTES);
      drain();
    end

    repeat (12) @(posedge clk);
    $display("Lexed %0d bytes in %0d streams and checked %0d tokens;", bytes_sent,
             streams_sent, tokens_seen);
    $display("covered escapes, cut-off literals, open strings at end and a long output stall.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* json_byte_tokenizer_core.f */
rtl/jbt_pkg.sv
rtl/jbt_if.sv
rtl/jbt_lexer.sv
rtl/jbt_tok_fifo.sv
rtl/json_byte_tokenizer_core.sv
bench/tb.sv
